FILE: sv/pinned_lru_page_cache_unit_assert.svh
// Assertion macros shared by the cache checker.
`ifndef PINNED_LRU_PAGE_CACHE_UNIT_ASSERT_SVH
`define PINNED_LRU_PAGE_CACHE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PLC_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

FILE: sv/plc_pkg.sv
// Package: types, constants and codes of the pinned LRU page cache.
`default_nettype none
package plc_pkg;
    localparam int NUM_PAGES   = 16;
    localparam int MAX_HANDLES = 16;
    localparam int PIN_BITS    = 8;
    localparam int PW = $clog2(NUM_PAGES);
    localparam int HW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int QW = $clog2(MAX_HANDLES + 1);

    localparam logic [1:0] CMD_TRYLOCK = 2'd0;
    localparam logic [1:0] CMD_UNLOCK  = 2'd1;
    localparam logic [1:0] CMD_ALLOC   = 2'd2;
    localparam logic [1:0] CMD_FREE    = 2'd3;

    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_EVICT  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_MISUSE  = 2'd2;
    localparam logic [1:0] ST_NOPAGES = 2'd3;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_PBYTE = 2'd1;
    localparam logic [1:0] REG_NPAGE = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] handle;
        logic [4:0] page_count;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  handle_out;
        logic [3:0]  page_index;
        logic [47:0] page_address;
        logic [1:0]  status;
        logic        last;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_FINDH, S_POPFREE, S_EVHEAD, S_EVRD, S_EVPAGE,
        S_EVDONE, S_CHECK, S_RETURN, S_GRRD, S_GRMUL, S_GROUT, S_EVOUT,
        S_STOUT, S_FRPAGE, S_FRDONE, S_QREM, S_INIT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        state_t st;
        logic   first;  // first cycle in the state
    } ctl_cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic done;     // current step finished
        logic branch;   // condition for the alternative next state
        logic out_busy; // output register holds an untaken word
    } dp_stat_t;
endpackage
`default_nettype wire

FILE: sv/plc_ctrl.sv
// Controller: sequences one command at a time through the datapath.
`default_nettype none
module plc_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 init_req,
    input  plc_pkg::dp_stat_t   stat,
    input  wire                 cmd_alloc,
    input  wire                 cmd_free_ok,
    input  wire                 cmd_quick,
    output plc_pkg::ctl_cmd_t   cmd
);
    import plc_pkg::*;

    state_t state_reg, state_next;
    logic   first_reg, first_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (init_req) state_next = S_INIT;
                else if (start) state_next = S_DECODE;
            S_INIT:
                if (stat.done) state_next = S_IDLE;
            S_DECODE:
                if (cmd_alloc) state_next = S_FINDH;
                else if (cmd_free_ok) state_next = S_QREM;
                else if (cmd_quick) state_next = S_STOUT;
                else state_next = S_STOUT;
            S_FINDH:
                state_next = stat.branch ? S_POPFREE : S_STOUT;
            S_POPFREE:
                if (stat.done) state_next = S_EVHEAD;
            S_EVHEAD:
                if (stat.done) state_next = S_CHECK;
                else state_next = S_QREM;
            S_QREM:
                if (stat.done) state_next = stat.branch ? S_EVRD : S_FRPAGE;
            S_EVRD:
                state_next = stat.done ? S_EVDONE : S_EVPAGE;
            S_EVPAGE:
                state_next = S_EVRD;
            S_EVDONE:
                state_next = S_EVHEAD;
            S_CHECK:
                state_next = stat.branch ? S_GRRD : S_RETURN;
            S_RETURN:
                if (stat.done) state_next = S_EVOUT;
            S_GRRD:
                state_next = stat.done ? S_EVOUT : S_GRMUL;
            S_GRMUL:
                state_next = S_GROUT;
            S_GROUT:
                if (!stat.out_busy) state_next = S_GRRD;
            S_EVOUT:
                if (stat.done) state_next = S_STOUT;
            S_FRPAGE:
                if (stat.done) state_next = S_FRDONE;
            S_FRDONE:
                if (!stat.out_busy) state_next = S_STOUT;
            S_STOUT:
                if (!stat.out_busy) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        first_next = (state_next != state_reg);
    end

    assign cmd.st    = state_reg;
    assign cmd.first = first_reg;
endmodule
`default_nettype wire

FILE: sv/plc_dpath.sv
// Datapath: cache state, page store, address multiply and output register.
`default_nettype none
module plc_dpath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  plc_pkg::ctl_cmd_t   cmd,
    output plc_pkg::dp_stat_t   stat,
    input  plc_pkg::in_word_t   in_word,
    input  wire                 in_take,
    input  wire                 cfg_take,
    input  wire [1:0]           cfg_index,
    input  wire [63:0]          cfg_data,
    output logic                init_req,
    output logic                cmd_alloc,
    output logic                cmd_free_ok,
    output logic                cmd_quick,
    output plc_pkg::out_word_t  out_word,
    output logic                out_valid,
    input  wire                 out_stall
);
    import plc_pkg::*;

    // Configuration
    logic [47:0] base_reg;
    logic [31:0] pbytes_reg;
    logic [4:0]  npages_reg;
    logic        init_pend_reg;

    // Cache state
    logic [PW-1:0]       fifo_reg [NUM_PAGES];
    logic [PW-1:0]       fhead_reg;
    logic [CW-1:0]       fcnt_reg;
    logic [HW-1:0]       q_reg [MAX_HANDLES];
    logic [QW-1:0]       qcnt_reg;
    logic [MAX_HANDLES-1:0] live_reg;
    logic [PIN_BITS-1:0] pin_reg [MAX_HANDLES];
    logic [CW-1:0]       hcnt_reg [MAX_HANDLES];

    // Page store: one row of pages per handle
    logic [PW-1:0] pstore [MAX_HANDLES*NUM_PAGES];
    logic [PW-1:0] prd_reg;

    // Command working registers
    in_word_t      cw_reg;
    logic [HW-1:0] nh_reg;
    logic          nh_found_reg;
    logic [PW-1:0] taken_reg [NUM_PAGES];
    logic [CW-1:0] n_reg;
    logic [HW-1:0] ev_reg [MAX_HANDLES];
    logic [QW-1:0] ne_reg;
    logic [HW-1:0] vic_reg;
    logic [CW-1:0] i_reg;
    logic [QW-1:0] qi_reg, qj_reg;
    logic [1:0]    st_reg;
    logic          okalloc_reg;
    logic [47:0]   addr_reg;
    out_word_t     ow_reg;
    logic          ov_reg;

    logic [HW-1:0] h_in;
    logic          h_live;
    logic [PIN_BITS-1:0] h_pin;
    logic [CW-1:0] pcnt_in;
    logic [CW-1:0] n_lim;
    logic          out_free;
    logic          push_ok;
    logic [PW-1:0] push_slot;
    logic [HW-1:0] qrem_h;
    logic [PW-1:0] taken_sel;
    logic [PW-1:0] rd_idx;
    logic [35:0]   prod;

    assign h_in    = cw_reg.handle[HW-1:0];
    assign h_live  = live_reg[h_in];
    assign h_pin   = pin_reg[h_in];
    assign pcnt_in = CW'(cw_reg.page_count);
    assign n_lim   = (npages_reg > 5'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(npages_reg);
    assign out_free = !ov_reg || !out_stall;
    assign push_ok  = fcnt_reg < CW'(NUM_PAGES);
    assign push_slot = PW'(fhead_reg + PW'(fcnt_reg));
    assign qrem_h   = (cmd.st == S_QREM && cw_reg.command == CMD_ALLOC) ? q_reg[0] : h_in;
    assign taken_sel = taken_reg[i_reg[PW-1:0]];
    assign prod     = 36'(taken_sel) * 36'(pbytes_reg);
    // A free streams one page a cycle, so its read runs one page ahead
    assign rd_idx   = (cmd.st == S_FRPAGE && !cmd.first) ? i_reg[PW-1:0] + 1'b1
                                                         : i_reg[PW-1:0];

    assign init_req   = init_pend_reg;
    assign cmd_alloc  = cw_reg.command == CMD_ALLOC;
    assign cmd_free_ok = cw_reg.command == CMD_FREE && h_live && h_pin == '0;
    assign cmd_quick  = 1'b1;

    // Trylock removal: entry k shifts once the handle is at or before k
    function automatic logic qj_pass(input int k);
        logic r;
        r = 1'b0;
        for (int m = 0; m < MAX_HANDLES; m++)
            if (m < k && q_reg[m] == h_in) r = 1'b1;
        return r;
    endfunction

    // Status to the controller
    always_comb
    begin
        stat.done = 1'b0;
        stat.branch = 1'b0;
        stat.out_busy = !out_free;
        case (cmd.st)
            S_INIT:    stat.done = !cmd.first && i_reg == CW'(NUM_PAGES - 1);
            S_FINDH:   stat.branch = nh_found_reg && pcnt_in != '0;
            S_POPFREE: stat.done = !(n_reg < pcnt_in && fcnt_reg != '0);
            S_EVHEAD:  stat.done = !(n_reg < pcnt_in && qcnt_reg != '0);
            S_QREM:
            begin
                stat.done = qi_reg >= qcnt_reg;
                stat.branch = cw_reg.command == CMD_ALLOC;
            end
            S_EVRD, S_GRRD, S_FRPAGE: stat.done = i_reg >= ((cmd.st == S_GRRD) ? n_reg
                                                    : hcnt_reg[vic_reg]);
            S_CHECK:   stat.branch = n_reg >= pcnt_in;
            S_RETURN:  stat.done = i_reg >= n_reg;
            S_EVOUT:   stat.done = qi_reg >= ne_reg && out_free;
            default:   stat.done = 1'b0;
        endcase
    end

    // Page store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.st == S_GROUT && out_free)
            pstore[{nh_reg, i_reg[PW-1:0]}] <= taken_sel;
        prd_reg <= pstore[{vic_reg, rd_idx}];
    end

    // Configuration, state updates and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            pbytes_reg <= 32'd4096;
            npages_reg <= 5'd16;
            init_pend_reg <= 1'b1;
            fhead_reg <= '0;
            fcnt_reg <= '0;
            qcnt_reg <= '0;
            live_reg <= '0;
            ov_reg <= 1'b0;
            i_reg <= '0;
            for (int k = 0; k < MAX_HANDLES; k++)
            begin
                pin_reg[k] <= '0;
                hcnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (cfg_take)
            begin
                case (cfg_index)
                    REG_BASE:  base_reg <= cfg_data[47:0];
                    REG_PBYTE: pbytes_reg <= cfg_data[31:0];
                    REG_NPAGE:
                    begin
                        npages_reg <= cfg_data[4:0];
                        init_pend_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (in_take)
                cw_reg <= in_word;
            case (cmd.st)
                S_INIT:
                begin
                    if (cmd.first)
                    begin
                        fhead_reg <= '0;
                        fcnt_reg <= n_lim;
                        qcnt_reg <= '0;
                        live_reg <= '0;
                        for (int k = 0; k < MAX_HANDLES; k++)
                        begin
                            pin_reg[k] <= '0;
                            hcnt_reg[k] <= '0;
                        end
                        i_reg <= '0;
                        init_pend_reg <= 1'b0;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                    fifo_reg[i_reg[PW-1:0]] <= cmd.first ? '0 : i_reg[PW-1:0];
                    if (stat.done)
                        i_reg <= '0;
                end
                S_DECODE:
                begin
                    n_reg <= '0;
                    ne_reg <= '0;
                    qi_reg <= '0;
                    qj_reg <= '0;
                    i_reg <= '0;
                    nh_found_reg <= !(&live_reg);
                    nh_reg <= '0;
                    for (int k = MAX_HANDLES - 1; k >= 0; k--)
                        if (!live_reg[k]) nh_reg <= HW'(k);
                    st_reg <= ST_OK;
                    okalloc_reg <= 1'b0;
                    case (cw_reg.command)
                        CMD_TRYLOCK:
                            if (!h_live) st_reg <= ST_REFUSED;
                            else if (&h_pin) st_reg <= ST_MISUSE;
                            else
                            begin
                                pin_reg[h_in] <= h_pin + 1'b1;
                                if (h_pin == '0)
                                begin
                                    // leave unpinned queue
                                    for (int k = 0; k < MAX_HANDLES - 1; k++)
                                    begin
                                        if (QW'(k) < qcnt_reg)
                                            q_reg[k] <= q_reg[k] == h_in || qj_pass(k)
                                                ? q_reg[k+1] : q_reg[k];
                                    end
                                    qcnt_reg <= qcnt_reg - 1'b1;
                                end
                            end
                        CMD_UNLOCK:
                            if (!h_live || h_pin == '0) st_reg <= ST_MISUSE;
                            else
                            begin
                                pin_reg[h_in] <= h_pin - 1'b1;
                                if (h_pin == PIN_BITS'(1) && qcnt_reg < QW'(MAX_HANDLES))
                                begin
                                    q_reg[qcnt_reg[HW-1:0]] <= h_in;
                                    qcnt_reg <= qcnt_reg + 1'b1;
                                end
                            end
                        CMD_FREE:
                            if (!h_live) st_reg <= ST_REFUSED;
                            else if (h_pin != '0) st_reg <= ST_MISUSE;
                            else vic_reg <= h_in;
                        default: ;
                    endcase
                end
                S_FINDH:
                    if (pcnt_in == '0) st_reg <= ST_MISUSE;
                    else if (!nh_found_reg) st_reg <= ST_NOPAGES;
                S_POPFREE:
                    if (!stat.done)
                    begin
                        taken_reg[n_reg[PW-1:0]] <= fifo_reg[fhead_reg];
                        fhead_reg <= fhead_reg + 1'b1;
                        fcnt_reg <= fcnt_reg - 1'b1;
                        n_reg <= n_reg + 1'b1;
                    end
                S_EVHEAD:
                begin
                    qi_reg <= '0;
                    qj_reg <= '0;
                    if (!stat.done)
                    begin
                        vic_reg <= q_reg[0];
                        ev_reg[ne_reg[HW-1:0]] <= q_reg[0];
                        ne_reg <= ne_reg + 1'b1;
                        live_reg[q_reg[0]] <= 1'b0;
                    end
                end
                S_QREM:
                begin
                    // compact the queue one entry a cycle
                    if (!stat.done)
                    begin
                        if (q_reg[qi_reg[HW-1:0]] != qrem_h)
                        begin
                            q_reg[qj_reg[HW-1:0]] <= q_reg[qi_reg[HW-1:0]];
                            qj_reg <= qj_reg + 1'b1;
                        end
                        qi_reg <= qi_reg + 1'b1;
                    end
                    else
                    begin
                        qcnt_reg <= qj_reg;
                        i_reg <= '0;
                        if (cw_reg.command != CMD_ALLOC)
                            vic_reg <= h_in;
                    end
                end
                S_EVRD:
                    ;
                S_EVPAGE:
                begin
                    if (n_reg < pcnt_in)
                    begin
                        taken_reg[n_reg[PW-1:0]] <= prd_reg;
                        n_reg <= n_reg + 1'b1;
                    end
                    else if (push_ok)
                    begin
                        fifo_reg[push_slot] <= prd_reg;
                        fcnt_reg <= fcnt_reg + 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                S_EVDONE:
                begin
                    hcnt_reg[vic_reg] <= '0;
                    pin_reg[vic_reg] <= '0;
                end
                S_CHECK:
                begin
                    i_reg <= '0;
                    qi_reg <= '0;
                    if (n_reg >= pcnt_in)
                    begin
                        okalloc_reg <= 1'b1;
                        live_reg[nh_reg] <= 1'b1;
                        pin_reg[nh_reg] <= PIN_BITS'(1);
                        hcnt_reg[nh_reg] <= n_reg;
                    end
                    else
                        st_reg <= ST_NOPAGES;
                end
                S_RETURN:
                    if (!stat.done)
                    begin
                        if (push_ok)
                        begin
                            fifo_reg[push_slot] <= taken_sel;
                            fcnt_reg <= fcnt_reg + 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                S_GRMUL:
                    addr_reg <= 48'(prod);
                S_GROUT:
                    if (out_free)
                    begin
                        ow_reg.kind <= KIND_GRANT;
                        ow_reg.handle_out <= 4'(nh_reg);
                        ow_reg.page_index <= 4'(taken_sel);
                        ow_reg.page_address <= base_reg + addr_reg;
                        ow_reg.status <= ST_OK;
                        ow_reg.last <= 1'b0;
                        ov_reg <= 1'b1;
                        i_reg <= i_reg + 1'b1;
                    end
                S_EVOUT:
                    if (out_free && qi_reg < ne_reg)
                    begin
                        ow_reg.kind <= KIND_EVICT;
                        ow_reg.handle_out <= 4'(ev_reg[qi_reg[HW-1:0]]);
                        ow_reg.page_index <= '0;
                        ow_reg.page_address <= '0;
                        ow_reg.status <= ST_REFUSED;
                        ow_reg.last <= 1'b0;
                        ov_reg <= 1'b1;
                        qi_reg <= qi_reg + 1'b1;
                    end
                S_FRPAGE:
                    if (!stat.done)
                    begin
                        if (!cmd.first)
                        begin
                            if (push_ok)
                            begin
                                fifo_reg[push_slot] <= prd_reg;
                                fcnt_reg <= fcnt_reg + 1'b1;
                            end
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                S_FRDONE:
                begin
                    hcnt_reg[vic_reg] <= '0;
                    live_reg[vic_reg] <= 1'b0;
                    if (out_free)
                    begin
                        ow_reg.kind <= KIND_EVICT;
                        ow_reg.handle_out <= cw_reg.handle;
                        ow_reg.page_index <= '0;
                        ow_reg.page_address <= '0;
                        ow_reg.status <= ST_REFUSED;
                        ow_reg.last <= 1'b0;
                        ov_reg <= 1'b1;
                    end
                end
                S_STOUT:
                    if (out_free)
                    begin
                        ow_reg.kind <= KIND_STATUS;
                        ow_reg.handle_out <= !cmd_alloc ? cw_reg.handle
                            : (okalloc_reg ? 4'(nh_reg) : 4'd0);
                        ow_reg.page_index <= '0;
                        ow_reg.page_address <= '0;
                        ow_reg.status <= st_reg;
                        ow_reg.last <= 1'b1;
                        ov_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

    assign out_word  = ow_reg;
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

FILE: sv/pinned_lru_page_cache_unit.sv
// Top level of the pinned LRU page cache.
//  channel | direction | handshake    | word
//  in      | input     | valid/stall  | in_word_t
//  out     | output    | valid/stall  | out_word_t
//  cfg     | input     | valid/ready  | index, data
// One command at a time. Trylock, unlock and refused commands go from decode
// straight to the status word; a free walks the queue, then returns its pages.
// An alloc pops free pages, then per victim walks the queue and reads back its
// pages, then sends one grant per page, then the evict words and the status.
// Grant addresses go through one registered 4x32 multiply per page.
// After reset and after a pages_in_use write, an init pass refills the
// free FIFO while no command is taken. A stalled output word holds the sequencer.
`default_nettype none
module pinned_lru_page_cache_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  plc_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  wire                 out_stall,
    output plc_pkg::out_word_t  out_word,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [63:0]          cfg_data
);
    import plc_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     init_req, cmd_alloc, cmd_free_ok, cmd_quick, in_take;

    assign in_stall  = !(cmd.st == S_IDLE && !init_req);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    plc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(in_take), .init_req(init_req),
        .stat(stat), .cmd_alloc(cmd_alloc), .cmd_free_ok(cmd_free_ok),
        .cmd_quick(cmd_quick), .cmd(cmd)
    );

    plc_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_word(in_word),
        .in_take(in_take), .cfg_take(cfg_valid && cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .init_req(init_req),
        .cmd_alloc(cmd_alloc), .cmd_free_ok(cmd_free_ok), .cmd_quick(cmd_quick),
        .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
    );
endmodule
`default_nettype wire

FILE: sv/plc_checker.sv
// Port checker for the page cache, bound to the top level.
`default_nettype none
`include "pinned_lru_page_cache_unit_assert.svh"
module plc_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input plc_pkg::out_word_t  out_word
);
    import plc_pkg::*;

    `PLC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
    `PLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
    `PLC_ASSERT_IMP(a_kind_ok, clk, rst_n, out_valid, out_word.kind != 2'd3)
    `PLC_ASSERT_IMP(a_last_status, clk, rst_n, out_valid, out_word.last == (out_word.kind == KIND_STATUS))
    `PLC_ASSERT_IMP(a_grant_ok, clk, rst_n, out_valid && out_word.kind == KIND_GRANT, out_word.status == ST_OK)
endmodule

bind pinned_lru_page_cache_unit plc_checker u_plc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire

FILE: tb/sv/tb_pinned_lru_page_cache_unit.sv
// Self-checking testbench of the pinned LRU page cache: driver, monitor and predictor.
`default_nettype none
module tb_pinned_lru_page_cache_unit;
    import plc_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_word;
    logic out_valid;
    logic out_stall;
    out_word_t out_word;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;

    pinned_lru_page_cache_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Cache shadow state
    logic [47:0] sh_base;
    logic [31:0] sh_pbytes;
    logic [4:0] sh_npages;
    logic [3:0] free_fifo [NUM_PAGES];
    int free_head;
    int free_cnt;
    logic [3:0] lru_q [$];
    bit live [MAX_HANDLES];
    int pins [MAX_HANDLES];
    logic [3:0] hpages [MAX_HANDLES][NUM_PAGES];
    int hpage_cnt [MAX_HANDLES];

    in_word_t cmd_queue [$];
    out_word_t expected_words [$];
    int errors;
    int cycles;
    int words_seen;
    int cmds_sent;
    bit hold_input;
    int in_gap;
    int out_gap;

    task automatic pool_reset();
        int n;
        n = (sh_npages > NUM_PAGES) ? NUM_PAGES : sh_npages;
        for (int i = 0; i < NUM_PAGES; i++)
            free_fifo[i] = (i < n) ? i[3:0] : 4'd0;
        free_head = 0;
        free_cnt = n;
        lru_q.delete();
        for (int h = 0; h < MAX_HANDLES; h++)
        begin
            live[h] = 0;
            pins[h] = 0;
            hpage_cnt[h] = 0;
        end
    endtask

    task automatic free_push(logic [3:0] p);
        if (free_cnt < NUM_PAGES)
        begin
            free_fifo[(free_head + free_cnt) % NUM_PAGES] = p;
            free_cnt++;
        end
    endtask

    task automatic lru_drop(logic [3:0] h);
        foreach (lru_q[i])
            if (lru_q[i] == h)
            begin
                lru_q.delete(i);
                break;
            end
    endtask

    task automatic expect_word(logic [1:0] k, logic [3:0] h, logic [3:0] p,
                               logic [47:0] a, logic [1:0] s, logic l);
        out_word_t w;
        w.kind = k;
        w.handle_out = h;
        w.page_index = p;
        w.page_address = a;
        w.status = s;
        w.last = l;
        expected_words = {expected_words, w};
    endtask

    // Predict the words caused by one accepted command
    task automatic predict_cache(in_word_t c);
        logic [3:0] taken [$];
        logic [3:0] evicted [$];
        logic [3:0] h;
        logic [3:0] v;
        logic [1:0] st;
        int nh;
        logic [79:0] prod;
        h = c.handle;
        if (c.command == CMD_ALLOC)
        begin
            if (c.page_count == 0)
            begin
                expect_word(KIND_STATUS, 0, 0, 0, ST_MISUSE, 1);
                return;
            end
            nh = -1;
            for (int i = 0; i < MAX_HANDLES; i++)
                if (!live[i] && nh < 0)
                    nh = i;
            if (nh < 0)
            begin
                expect_word(KIND_STATUS, 0, 0, 0, ST_NOPAGES, 1);
                return;
            end
            while (taken.size() < c.page_count && free_cnt > 0)
            begin
                taken = {taken, free_fifo[free_head]};
                free_head = (free_head + 1) % NUM_PAGES;
                free_cnt--;
            end
            while (taken.size() < c.page_count && lru_q.size() > 0)
            begin
                v = lru_q.pop_front();
                evicted = {evicted, v};
                live[v] = 0;
                for (int i = 0; i < hpage_cnt[v]; i++)
                    if (taken.size() < c.page_count)
                        taken = {taken, hpages[v][i]};
                    else
                        free_push(hpages[v][i]);
                hpage_cnt[v] = 0;
                pins[v] = 0;
            end
            if (taken.size() < c.page_count)
            begin
                foreach (taken[i])
                    free_push(taken[i]);
                foreach (evicted[i])
                    expect_word(KIND_EVICT, evicted[i], 0, 0, ST_REFUSED, 0);
                expect_word(KIND_STATUS, 0, 0, 0, ST_NOPAGES, 1);
                return;
            end
            live[nh] = 1;
            pins[nh] = 1;
            hpage_cnt[nh] = taken.size();
            foreach (taken[i])
            begin
                hpages[nh][i] = taken[i];
                prod = {32'd0, sh_base} + taken[i] * {48'd0, sh_pbytes};
                expect_word(KIND_GRANT, nh[3:0], taken[i], prod[47:0], ST_OK, 0);
            end
            foreach (evicted[i])
                expect_word(KIND_EVICT, evicted[i], 0, 0, ST_REFUSED, 0);
            expect_word(KIND_STATUS, nh[3:0], 0, 0, ST_OK, 1);
            return;
        end
        if (c.command == CMD_TRYLOCK)
        begin
            if (!live[h])
                st = ST_REFUSED;
            else if (pins[h] >= (1 << PIN_BITS) - 1)
                st = ST_MISUSE;
            else
            begin
                if (pins[h] == 0)
                    lru_drop(h);
                pins[h]++;
                st = ST_OK;
            end
        end
        else if (c.command == CMD_UNLOCK)
        begin
            if (!live[h] || pins[h] == 0)
                st = ST_MISUSE;
            else
            begin
                pins[h]--;
                if (pins[h] == 0)
                    lru_q = {lru_q, h};
                st = ST_OK;
            end
        end
        else
        begin
            if (!live[h])
                st = ST_REFUSED;
            else if (pins[h] != 0)
                st = ST_MISUSE;
            else
            begin
                lru_drop(h);
                for (int i = 0; i < hpage_cnt[h]; i++)
                    free_push(hpages[h][i]);
                hpage_cnt[h] = 0;
                live[h] = 0;
                expect_word(KIND_EVICT, h, 0, 0, ST_REFUSED, 0);
                expect_word(KIND_STATUS, h, 0, 0, ST_OK, 1);
                return;
            end
        end
        expect_word(KIND_STATUS, h, 0, 0, st, 1);
    endtask

    function automatic in_word_t mk_cmd(logic [1:0] op, logic [3:0] h, logic [4:0] n);
        in_word_t c;
        c.command = op;
        c.handle = h;
        c.page_count = n;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic queue_cmd(in_word_t c);
        cmd_queue = {cmd_queue, c};
    endtask

    // Random command mix: alloc, unlock, trylock and free a quarter each; others use handles 0 to 7
    task automatic queue_random(int count, int max_pages);
        logic [1:0] op;
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                op = CMD_ALLOC;
            else if (r < 50)
                op = CMD_UNLOCK;
            else if (r < 75)
                op = CMD_TRYLOCK;
            else
                op = CMD_FREE;
            if (op == CMD_ALLOC)
                queue_cmd(mk_cmd(op, 4'($urandom),
                    ($urandom_range(0, 29) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, max_pages))));
            else
                queue_cmd(mk_cmd(op, 4'($urandom_range(0, 7)), 5'($urandom)));
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_BASE)
            sh_base = val[47:0];
        else if (idx == REG_PBYTE)
            sh_pbytes = val[31:0];
        else
        begin
            sh_npages = val[4:0];
            pool_reset();
        end
        repeat (30) @(posedge clk);
    endtask

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_cache(in_word);
                cmds_sent <= cmds_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (cmd_queue.size() > 0 && !hold_input)
                begin
                    in_word <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected word actual %p", $time, out_word);
                    errors <= errors + 1;
                end
                else if (expected_words[0] !== out_word)
                begin
                    $display("%0t mismatch expected %p actual %p",
                             $time, expected_words[0], out_word);
                    errors <= errors + 1;
                    void'(expected_words.pop_front());
                end
                else
                    void'(expected_words.pop_front());
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    out_gap <= pick_gap();
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        words_seen = 0;
        cmds_sent = 0;
        hold_input = 1'b0;
        sh_base = '0;
        sh_pbytes = 32'd4096;
        sh_npages = 5'd16;
        pool_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (30) @(posedge clk);

        // Directed: dead handles, zero request, eviction, shortfall, frees
        queue_cmd(mk_cmd(CMD_TRYLOCK, 4'd15, 5'd0));
        queue_cmd(mk_cmd(CMD_UNLOCK, 4'd0, 5'd31));
        queue_cmd(mk_cmd(CMD_FREE, 4'd3, 5'd0));
        queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_ALLOC, 4'd15, 5'd16));
        queue_cmd(mk_cmd(CMD_FREE, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_UNLOCK, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_UNLOCK, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd5));
        queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd17));
        queue_cmd(mk_cmd(CMD_TRYLOCK, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_FREE, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_UNLOCK, 4'd0, 5'd0));
        queue_cmd(mk_cmd(CMD_FREE, 4'd0, 5'd0));
        for (int i = 0; i < 5; i++)
            queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd1));
        wait_drained();

        // Pin overflow and handle exhaustion with the page count clamped to the full pool
        write_reg(REG_NPAGE, 64'd31);
        write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PBYTE, 64'hFFFF_FFFF);
        queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd1));
        repeat (255)
            queue_cmd(mk_cmd(CMD_TRYLOCK, 4'd0, 5'd0));
        for (int i = 0; i < 16; i++)
            queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd1));
        wait_drained();

        // Random phases over several pool settings
        write_reg(REG_NPAGE, 64'd16);
        write_reg(REG_BASE, 64'h0000_1234_5678_9ABC);
        write_reg(REG_PBYTE, 64'd1);
        queue_random(14, 16);
        wait_drained();
        write_reg(REG_NPAGE, 64'd1);
        queue_random(8, 2);
        wait_drained();
        write_reg(REG_NPAGE, 64'd0);
        queue_cmd(mk_cmd(CMD_ALLOC, 4'd0, 5'd1));
        wait_drained();
        write_reg(REG_NPAGE, 64'd6);
        write_reg(REG_PBYTE, 64'hA5A5_5A5A);
        write_reg(REG_BASE, 64'h5555_AAAA_5555);
        queue_random(8, 4);
        // Hold input until everything so far has come back
        while (cmd_queue.size() > 4)
            @(posedge clk);
        hold_input = 1'b1;
        while (in_valid || expected_words.size() > 0)
            @(posedge clk);
        hold_input = 1'b0;
        queue_random(8, 8);
        wait_drained();

        $display("sent %0d commands, checked %0d words over several pool settings",
                 cmds_sent, words_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/plc_pkg.sv
sv/plc_ctrl.sv
sv/plc_dpath.sv
sv/pinned_lru_page_cache_unit.sv
sv/plc_checker.sv
tb/sv/tb_pinned_lru_page_cache_unit.sv
